FILE: hw/rtl/msc_pkg.sv
// Shared types and constants for the monotonic stack count block.
// Used by msc_front, msc_back and the top level; depends on nothing.
package msc_pkg;

   localparam int FIELD_POS_BITS = 16;
   localparam int HEIGHT_BITS    = 32;
   localparam int COUNT_BITS     = 11;

   // Item kinds on the request side.
   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Command queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // Classified command: key holds the position of a push or the bound of a query.
   typedef struct packed {
      logic                      is_query;
      logic [FIELD_POS_BITS-1:0] key;
      logic [HEIGHT_BITS-1:0]    height;
   } cmd_type;

endpackage

FILE: hw/rtl/monotonic_stack_count_beyond_top.sv
// Channel   Ports                                             Beat taken when
// request   req_push/req_full, kind position height bound     req_push && !req_full
// response  rsp_empty/rsp_pop, count overflow                 rsp_pop && !rsp_empty
//
// A request is registered in a four-entry command queue, then the back end runs it.
// Push: written at once on an empty stack, else taken, then each entry no taller is popped
// and the new entry written, along with the last pop if the walk empties the stack.
// Query: a binary search, one probe per position RAM read.
// Synchronous active-high reset empties the stack and clears the overflow flag.
// A waiting response keeps a query from starting; pushes run, but not past a blocked query.
// Top level of the monotonic stack count block; depends on msc_pkg, msc_front, msc_back.
module monotonic_stack_count_beyond_top #(
   parameter int STACK_DEPTH   = 1024,
   parameter int POSITION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_kind,
   input  logic [msc_pkg::FIELD_POS_BITS-1:0] req_position,
   input  logic [msc_pkg::HEIGHT_BITS-1:0]    req_height,
   input  logic [msc_pkg::FIELD_POS_BITS-1:0] req_bound,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [msc_pkg::COUNT_BITS-1:0]     rsp_count,
   output logic                              rsp_overflow
);

   logic             cmd_valid;
   logic             cmd_take;
   msc_pkg::cmd_type cmd;

   msc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_height   (req_height),
      .req_bound    (req_bound),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_take     (cmd_take)
   );

   msc_back #(
      .STACK_DEPTH   (STACK_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_take     (cmd_take),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_count    (rsp_count),
      .rsp_overflow (rsp_overflow)
   );

endmodule

FILE: hw/rtl/msc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the stack position and height stores.
module msc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/msc_front.sv
// Front end: accepts request beats, classifies them into commands and queues them.
// Depends on msc_pkg.
module msc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_kind,
   input  logic [msc_pkg::FIELD_POS_BITS-1:0] req_position,
   input  logic [msc_pkg::HEIGHT_BITS-1:0]    req_height,
   input  logic [msc_pkg::FIELD_POS_BITS-1:0] req_bound,
   output logic                              cmd_valid,
   output msc_pkg::cmd_type                  cmd,
   input  logic                              cmd_take
);

   msc_pkg::cmd_type                 queue_ff [msc_pkg::QUEUE_DEPTH];
   logic [msc_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [msc_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [msc_pkg::QUEUE_AW:0]       fill_ff, fill_in;
   msc_pkg::cmd_type                 new_cmd;
   logic                             accept;
   logic                             take;

   always_comb begin
      new_cmd.is_query = (req_kind == msc_pkg::KIND_QUERY);
      new_cmd.key      = new_cmd.is_query ? req_bound : req_position;
      new_cmd.height   = req_height;
   end

   assign req_full  = (fill_ff == (msc_pkg::QUEUE_AW + 1)'(msc_pkg::QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign take      = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept && !take) begin
         fill_in = fill_ff + 1'b1;
      end else if (take && !accept) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: hw/rtl/msc_back.sv
// Back end: runs pushes (pop walk, then write) and queries (binary search) on the stack.
// Depends on msc_pkg and msc_ram; holds the one-beat result buffer.
module msc_back #(
   parameter int STACK_DEPTH   = 1024,
   parameter int POSITION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  msc_pkg::cmd_type              cmd,
   output logic                          cmd_take,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [msc_pkg::COUNT_BITS-1:0] rsp_count,
   output logic                          rsp_overflow
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int KeyBits = (POSITION_BITS < msc_pkg::FIELD_POS_BITS) ?
                            POSITION_BITS : msc_pkg::FIELD_POS_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_POP    = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_FINAL  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic                            ovf_ff, ovf_in;
   logic [POSITION_BITS-1:0]        key_ff, key_in;
   logic [msc_pkg::HEIGHT_BITS-1:0] height_ff, height_in;
   logic [AW-1:0]                   lo_ff, lo_in;
   logic [AW-1:0]                   hi_ff, hi_in;
   logic [AW-1:0]                   mid_ff, mid_in;
   logic                            out_valid_ff, out_valid_in;
   logic [msc_pkg::COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic                            out_ovf_ff, out_ovf_in;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [AW-1:0]                   h_rd_addr;
   logic [AW-1:0]                   p_rd_addr;
   logic [msc_pkg::HEIGHT_BITS-1:0] h_rd_data;
   logic [POSITION_BITS-1:0]        p_rd_data;

   logic [POSITION_BITS-1:0]        cmd_key;
   logic [CW-1:0]                   cnt_m1;
   logic [CW-1:0]                   cnt_m2;
   logic [AW-1:0]                   half_cnt;
   logic                            pos_gt;
   logic [AW-1:0]                   lo_n, hi_n;
   logic [AW:0]                     mid_sum;
   logic [CW-1:0]                   lo_plus1;
   logic                            load_out;
   logic [CW-1:0]                   result_cnt;

   msc_ram #(.WIDTH(msc_pkg::HEIGHT_BITS), .DEPTH(STACK_DEPTH)) u_height_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (height_in),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   msc_ram #(.WIDTH(POSITION_BITS), .DEPTH(STACK_DEPTH)) u_position_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_in),
      .rd_addr (p_rd_addr),
      .rd_data (p_rd_data)
   );

   assign cmd_key  = POSITION_BITS'(cmd.key[KeyBits-1:0]);
   assign cnt_m1   = cnt_ff - CW'(1);
   assign cnt_m2   = cnt_ff - CW'(2);
   assign half_cnt = AW'(cnt_ff >> 1);
   assign pos_gt   = (p_rd_data > key_ff);
   assign lo_n     = pos_gt ? mid_ff : lo_ff;
   assign hi_n     = pos_gt ? hi_ff : mid_ff - AW'(1);
   assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n} + (AW + 1)'(1);
   assign lo_plus1 = CW'(lo_ff) + CW'(1);

   // A query may start only when the result buffer is free or drains this cycle.
   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid &&
                     (!cmd.is_query || !out_valid_ff || rsp_pop);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      key_in     = key_ff;
      height_in  = height_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      wr_en      = 1'b0;
      wr_addr    = cnt_ff[AW-1:0];
      h_rd_addr  = cnt_m2[AW-1:0];
      p_rd_addr  = mid_ff;
      load_out   = 1'b0;
      result_cnt = '0;

      case (state_ff)
         ST_IDLE: begin
            h_rd_addr = cnt_m1[AW-1:0];
            if (cmd_take) begin
               key_in    = cmd_key;
               height_in = cmd.height;
               if (!cmd.is_query) begin
                  if (cnt_ff == '0) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     cnt_in  = CW'(1);
                  end else begin
                     state_in = ST_POP;
                  end
               end else if (cnt_ff == '0) begin
                  load_out = 1'b1;
               end else begin
                  lo_in = '0;
                  hi_in = cnt_m1[AW-1:0];
                  if (cnt_m1 == '0) begin
                     p_rd_addr = '0;
                     state_in  = ST_FINAL;
                  end else begin
                     // First probe: (0 + hi + 1) / 2 = cnt / 2
                     mid_in    = half_cnt;
                     p_rd_addr = half_cnt;
                     state_in  = ST_SEARCH;
                  end
               end
            end
         end

         ST_POP: begin
            // Read data is the height of the current top; the entry below is read ahead.
            if (h_rd_data <= height_ff) begin
               cnt_in = cnt_m1;
               if (cnt_m1 == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  cnt_in   = CW'(1);
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
               if (cnt_ff >= CW'(STACK_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end

         ST_SEARCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_in    = mid_sum[AW:1];
               p_rd_addr = mid_sum[AW:1];
            end else begin
               p_rd_addr = lo_n;
               state_in  = ST_FINAL;
            end
         end

         ST_FINAL: begin
            load_out   = 1'b1;
            result_cnt = pos_gt ? lo_plus1 : '0;
            state_in   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_count_in = out_count_ff;
      out_ovf_in   = out_ovf_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_count_in = msc_pkg::COUNT_BITS'(result_cnt);
         out_ovf_in   = ovf_ff;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      height_ff    <= height_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      out_count_ff <= out_count_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_count    = out_count_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule

FILE: verif/msc_count_checker.sv
// Checker for the monotonic stack count block: watches both queue channels,
// predicts each query answer from its own copy of the stack, and counts mismatches.
// Depends on msc_pkg only.
`timescale 1ns / 1ps

module msc_count_checker #(
   parameter int STACK_DEPTH   = 1024,
   parameter int POSITION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic                               req_full,
   input  logic                               req_kind,
   input  logic [msc_pkg::FIELD_POS_BITS-1:0] req_position,
   input  logic [msc_pkg::HEIGHT_BITS-1:0]    req_height,
   input  logic [msc_pkg::FIELD_POS_BITS-1:0] req_bound,
   input  logic                               rsp_empty,
   input  logic                               rsp_pop,
   input  logic [msc_pkg::COUNT_BITS-1:0]     rsp_count,
   input  logic                               rsp_overflow,
   output int                                 fail_count,
   output int                                 answers_pending
);

   localparam logic [msc_pkg::FIELD_POS_BITS-1:0] POS_MASK =
      msc_pkg::FIELD_POS_BITS'((64'd1 << POSITION_BITS) - 64'd1);

   typedef struct packed {
      logic [msc_pkg::COUNT_BITS-1:0] count;
      logic                           overflow;
   } answer_type;

   logic [msc_pkg::FIELD_POS_BITS-1:0] stk_pos    [STACK_DEPTH];
   logic [msc_pkg::HEIGHT_BITS-1:0]    stk_height [STACK_DEPTH];
   int unsigned                        depth_now;
   logic                               dropped_seen;
   answer_type                         answers_due [$];

   // Pop every entry no taller than the newcomer, then place it unless still full.
   function automatic void stack_building(logic [msc_pkg::FIELD_POS_BITS-1:0] pos,
                                          logic [msc_pkg::HEIGHT_BITS-1:0] h);
      while (depth_now > 0 && stk_height[depth_now-1] <= h)
         depth_now--;
      if (depth_now >= STACK_DEPTH) begin
         dropped_seen = 1'b1;
      end else begin
         stk_pos[depth_now]    = pos;
         stk_height[depth_now] = h;
         depth_now++;
      end
   endfunction

   // Largest prefix whose last entry lies beyond the bound, found by halving.
   function automatic logic [msc_pkg::COUNT_BITS-1:0] count_above(
      logic [msc_pkg::FIELD_POS_BITS-1:0] b);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (depth_now == 0 || depth_now > STACK_DEPTH)
         return '0;
      lo = 0;
      hi = depth_now - 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (stk_pos[mid] > b)
            lo = mid;
         else
            hi = mid - 1;
      end
      if (stk_pos[lo] > b)
         return msc_pkg::COUNT_BITS'(lo + 1);
      return '0;
   endfunction

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         depth_now    = 0;
         dropped_seen = 1'b0;
         fail_count   = 0;
         answers_due.delete();
      end else begin
         // Check the outgoing beat first: it can only answer an earlier query.
         if (rsp_pop && !rsp_empty) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no query waiting: count %0d overflow %0d",
                      rsp_count, rsp_overflow);
               fail_count++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_count !== due.count) begin
                  $error("count mismatch: expected %0d, actual %0d", due.count, rsp_count);
                  fail_count++;
               end
               if (rsp_overflow !== due.overflow) begin
                  $error("overflow mismatch: expected %0d, actual %0d",
                         due.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_kind == msc_pkg::KIND_QUERY) begin
               due.count    = count_above(req_bound & POS_MASK);
               due.overflow = dropped_seen;
               answers_due  = {answers_due, due};
            end else begin
               stack_building(req_position & POS_MASK, req_height);
            end
         end
      end
      answers_pending = answers_due.size();
   end

endmodule

FILE: verif/tb_top.sv
// Top of the monotonic stack count testbench: clock, reset, request and response
// stimulus, watchdog and verdict. Depends on msc_pkg, msc_count_checker and the block.
`timescale 1ns / 1ps

module tb_top;

   localparam int STACK_DEPTH   = 1024;
   localparam int POSITION_BITS = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 1200;
   localparam int STALL_LIMIT   = 20000;

   logic                               clock;
   logic                               reset;
   logic                               req_push;
   logic                               req_full;
   logic                               req_kind;
   logic [msc_pkg::FIELD_POS_BITS-1:0] req_position;
   logic [msc_pkg::HEIGHT_BITS-1:0]    req_height;
   logic [msc_pkg::FIELD_POS_BITS-1:0] req_bound;
   logic                               rsp_empty;
   logic                               rsp_pop;
   logic [msc_pkg::COUNT_BITS-1:0]     rsp_count;
   logic                               rsp_overflow;

   int fail_count;
   int answers_pending;
   int send_idle_pct;
   int take_idle_pct;
   bit hold_arm;
   int stall_cycles;
   int pos_cursor;
   logic [msc_pkg::HEIGHT_BITS-1:0] height_cursor;

   monotonic_stack_count_beyond_top #(
      .STACK_DEPTH   (STACK_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_height   (req_height),
      .req_bound    (req_bound),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_count    (rsp_count),
      .rsp_overflow (rsp_overflow)
   );

   msc_count_checker #(
      .STACK_DEPTH   (STACK_DEPTH),
      .POSITION_BITS (POSITION_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_height      (req_height),
      .req_bound       (req_bound),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_count       (rsp_count),
      .rsp_overflow    (rsp_overflow),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one beat at the falling edge and hold it until taken.
   task automatic offer(input logic kind, input logic [msc_pkg::FIELD_POS_BITS-1:0] pos,
                        input logic [msc_pkg::HEIGHT_BITS-1:0] h,
                        input logic [msc_pkg::FIELD_POS_BITS-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push     <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_height   <= h;
      req_bound    <= b;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic push_bldg(input logic [msc_pkg::FIELD_POS_BITS-1:0] pos,
                            input logic [msc_pkg::HEIGHT_BITS-1:0] h);
      offer(msc_pkg::KIND_PUSH, pos, h, msc_pkg::FIELD_POS_BITS'($urandom()));
   endtask

   task automatic ask(input logic [msc_pkg::FIELD_POS_BITS-1:0] b);
      offer(msc_pkg::KIND_QUERY, msc_pkg::FIELD_POS_BITS'($urandom()), $urandom(), b);
   endtask

   // Start a fresh run of positions: the tallest height sweeps the whole stack.
   task automatic restart_run();
      pos_cursor    = 65535 - $urandom_range(0, 15);
      height_cursor = 32'hFFFF_FFFF;
      push_bldg(msc_pkg::FIELD_POS_BITS'(pos_cursor), height_cursor);
   endtask

   task automatic random_burst(input int n);
      int r;
      int nb;
      int step;
      logic [msc_pkg::HEIGHT_BITS-1:0] h;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            if ($urandom_range(0, 2) == 0) begin
               nb = $urandom_range(0, 65535);
            end else begin
               nb = pos_cursor + $urandom_range(0, 800);
               if (nb > 65535)
                  nb = 65535;
            end
            ask(msc_pkg::FIELD_POS_BITS'(nb));
         end else if (r < 40) begin
            // noise: position out of order, any height
            push_bldg(msc_pkg::FIELD_POS_BITS'($urandom()), $urandom());
         end else if (r < 43) begin
            restart_run();
         end else begin
            step = $urandom_range(1, 40);
            if (pos_cursor - step < 64) begin
               restart_run();
            end else begin
               pos_cursor -= step;
               if (height_cursor > 32'h0400_0000 && $urandom_range(0, 3) != 0)
                  h = height_cursor - $urandom_range(1, 32'h03FF_FFFF);
               else
                  h = $urandom();
               height_cursor = h;
               push_bldg(msc_pkg::FIELD_POS_BITS'(pos_cursor), h);
            end
         end
      end
   endtask

   // Receiver: random pops, plus one long hold-off counted here.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_pop   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= take_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("** monotonic_stack_count_beyond_top: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [msc_pkg::HEIGHT_BITS-1:0] top_h;
      logic [msc_pkg::HEIGHT_BITS-1:0] h;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_kind      = msc_pkg::KIND_PUSH;
      req_position  = '0;
      req_height    = '0;
      req_bound     = '0;
      hold_arm      = 1'b0;
      stall_cycles  = 0;
      send_idle_pct = 12;
      take_idle_pct = 88;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty stack, equal heights, full sweep, out-of-order position
      ask(16'h0000);
      ask(16'hFFFF);
      push_bldg(16'hFFFF, 32'h0000_0000);
      ask(16'hFFFF);
      ask(16'h0000);
      ask(16'hFFFE);
      push_bldg(16'h8000, 32'h0000_0000);
      push_bldg(16'h7FFF, 32'hFFFF_FFFF);
      push_bldg(16'h4000, 32'h0000_1000);
      push_bldg(16'h2000, 32'h0000_0010);
      push_bldg(16'h0000, 32'h0000_0000);
      ask(16'h0000);
      ask(16'h1FFF);
      ask(16'h2000);
      ask(16'h4000);
      ask(16'h7FFE);
      ask(16'h7FFF);
      push_bldg(16'h9000, 32'h0000_0005);
      ask(16'h3000);
      ask(16'h8000);
      ask(16'h8FFF);
      pos_cursor    = 16'hFFFF;
      height_cursor = 32'hFFFF_FFFF;
      push_bldg(msc_pkg::FIELD_POS_BITS'(pos_cursor), height_cursor);

      random_burst(20);

      // fill the stack to its depth, then drop pushes on a full stack
      restart_run();
      top_h = height_cursor;
      for (int i = 0; i < STACK_DEPTH + 6; i++) begin
         // swap idling halfway: sender mostly idle, receiver mostly busy
         if (i == STACK_DEPTH / 2) begin
            send_idle_pct = 88;
            take_idle_pct <= 12;
         end
         pos_cursor -= $urandom_range(1, 20);
         h = height_cursor - $urandom_range(1, 32'h001F_FFFF);
         height_cursor = h;
         if (i == STACK_DEPTH - 2)
            top_h = h;
         push_bldg(msc_pkg::FIELD_POS_BITS'(pos_cursor), h);
         if (i % 64 == 63)
            ask(msc_pkg::FIELD_POS_BITS'($urandom()));
      end
      ask(16'h0000);
      ask(16'hFFFF);
      ask(msc_pkg::FIELD_POS_BITS'(pos_cursor + 100));
      // equal height pops the top, which makes room again
      pos_cursor -= 1;
      push_bldg(msc_pkg::FIELD_POS_BITS'(pos_cursor), top_h);
      ask(16'h0000);
      push_bldg(msc_pkg::FIELD_POS_BITS'(pos_cursor - 1), 32'h0000_0000);
      ask(16'h0000);
      restart_run();
      ask(16'h0000);

      // no idling; a held receiver lets queries back up until the input stalls
      send_idle_pct = 0;
      take_idle_pct <= 0;
      hold_arm <= 1'b1;
      repeat (6) ask(msc_pkg::FIELD_POS_BITS'($urandom()));
      random_burst(30);

      req_push <= 1'b0;
      while (answers_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("** monotonic_stack_count_beyond_top: PASSED **");
      else
         $display("** monotonic_stack_count_beyond_top: FAILED **");
      $finish;
   end

endmodule
